// ===== design/psmr_pkg.sv =====
// shared types and constants of the per-source message reassembly block
package psmr_pkg;

  localparam int WORD_W = 32;
  localparam int NODE_W = 2;

  // action codes
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // side information that travels with a result item
  typedef struct packed {
    logic is_read;
    logic last;
    logic dropped;
  } psmr_meta_t;

endpackage

// ===== design/psmr_ram.sv =====
// generic single-write, single-read ram with registered read data
module psmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 192
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/per_source_message_reassembly.sv =====
// per-source message reassembly: region store, fill counters and read-out
// a result item is shown in the cycle after its input item is accepted
// throughput: one item per cycle while in_stall is low; the store ram takes one write or one read per item
// the output register holds a result under stall; the input side stalls then
// and during the clearing pass
// reset: fills, read pointer and own_node go to zero, then a clearing pass over
// all (NODES-1)*MESSAGE_WORDS store words zeroes the store ram while in_stall stays high
module per_source_message_reassembly #(
  parameter int NODES         = 4,
  parameter int MESSAGE_WORDS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [psmr_pkg::NODE_W-1:0] cfg_wr_data,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [psmr_pkg::NODE_W-1:0] in_source_node,
  input  logic [psmr_pkg::WORD_W-1:0] in_word_data,
  input  logic                        in_packet_last,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [psmr_pkg::WORD_W-1:0] out_read_data,
  output logic                        out_read_last,
  output logic                        out_word_dropped
);

  localparam int REGIONS = NODES - 1;
  localparam int DEPTH   = REGIONS * MESSAGE_WORDS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW      = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int FW      = $clog2(MESSAGE_WORDS + 1);

  // own node id
  logic [psmr_pkg::NODE_W-1:0] own_node_r;

  // per-region fill counts and the read-out pointer
  logic [FW-1:0] fill_r [REGIONS];
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;

  // clearing pass after reset
  logic          clearing_r, clearing_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // output stage
  logic                 out_valid_r, out_valid_nxt;
  psmr_pkg::psmr_meta_t meta_r, meta_nxt;
  logic [psmr_pkg::WORD_W-1:0] ram_rdata;

  logic in_acc;
  logic is_read;
  logic [psmr_pkg::NODE_W-1:0] region;
  logic          region_ok;
  logic [RW-1:0] ridx;
  logic [FW-1:0] fill_cur;
  logic          st_drop;
  logic          st_write;
  logic [AW-1:0] st_addr;
  logic          rd_last;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [psmr_pkg::WORD_W-1:0] ram_wdata;

  // a new item may enter whenever the output register is free or being taken and no clearing pass runs
  assign in_stall = clearing_r || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign is_read  = (in_action == psmr_pkg::ACT_READ);

  // source ids above our own shift down by one, own id takes no region
  always_comb begin
    region    = (in_source_node > own_node_r) ? in_source_node - 1'b1 : in_source_node;
    region_ok = (in_source_node != own_node_r) && (int'(region) < REGIONS);
    ridx      = RW'(region);
    fill_cur  = region_ok ? fill_r[ridx] : '0;
    st_drop   = !region_ok || (int'(fill_cur) >= MESSAGE_WORDS);
    st_write  = in_acc && !is_read && !st_drop;
    st_addr   = AW'(ridx) * AW'(MESSAGE_WORDS) + AW'(fill_cur);
    rd_last   = (int'(rd_ptr_r) == DEPTH - 1);
  end

  // ram write port: clearing pass first, then stored words
  always_comb begin
    ram_we    = clearing_r || st_write;
    ram_waddr = clearing_r ? clr_cnt_r : st_addr;
    ram_wdata = clearing_r ? '0 : in_word_data;
  end

  // in_packet_last needs no handling: each word is appended on its own

  psmr_ram #(
    .WIDTH(psmr_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_acc && is_read),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (int'(clr_cnt_r) == DEPTH - 1) begin
        clearing_nxt = 1'b0;
      end
    end

    rd_ptr_nxt = rd_ptr_r;
    if (in_acc && is_read) begin
      rd_ptr_nxt = rd_last ? '0 : rd_ptr_r + 1'b1;
    end

    out_valid_nxt = out_valid_r;
    meta_nxt      = meta_r;
    if (in_acc) begin
      out_valid_nxt    = 1'b1;
      meta_nxt.is_read = is_read;
      meta_nxt.last    = is_read && rd_last;
      meta_nxt.dropped = !is_read && st_drop;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_node_r  <= '0;
      rd_ptr_r    <= '0;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < REGIONS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        own_node_r <= cfg_wr_data;
      end
      rd_ptr_r    <= rd_ptr_nxt;
      clearing_r  <= clearing_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      // the final read word empties every region
      if (in_acc && is_read && rd_last) begin
        for (int i = 0; i < REGIONS; i++) begin
          fill_r[i] <= '0;
        end
      end else if (st_write) begin
        fill_r[ridx] <= fill_cur + 1'b1;
      end
    end
  end

  // payload of the output stage needs no reset
  always_ff @(posedge clk) begin
    meta_r <= meta_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = meta_r.is_read ? ram_rdata : '0;
  assign out_read_last    = meta_r.last;
  assign out_word_dropped = meta_r.dropped;

  // no item enters while the store is being cleared
  a_no_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_acc)
    else $error("item accepted during clearing pass");

  // the final read word rewinds the pointer and empties region zero
  a_last_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_read && rd_last |=> (rd_ptr_r == '0) && (fill_r[0] == '0))
    else $error("final read did not rewind");

  // region zero never holds more than its size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r[0]) <= MESSAGE_WORDS)
    else $error("region fill past its size");

  // a result is either a read or a store outcome, never both
  a_meta_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(meta_r.last && meta_r.dropped))
    else $error("read_last and word_dropped both set");

  // no payload word is written while the clearing pass owns the write port
  a_clear_write: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !st_write)
    else $error("store write during clearing pass");

endmodule

// ===== verif/tb_per_source_message_reassembly.sv =====
// self-checking testbench of the per-source message reassembly block
module tb_per_source_message_reassembly;

  localparam int NODES         = 4;
  localparam int MESSAGE_WORDS = 64;
  localparam int REGIONS       = NODES - 1;
  localparam int STORE_WORDS   = REGIONS * MESSAGE_WORDS;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 200;
  localparam int DRAIN_CYCLES  = 8;

  // one input item as the sender offers it
  typedef struct packed {
    logic                        action;
    logic [psmr_pkg::NODE_W-1:0] source_node;
    logic [psmr_pkg::WORD_W-1:0] word_data;
    logic                        packet_last;
  } reasm_item_t;

  // one result item as the block returns it
  typedef struct packed {
    logic [psmr_pkg::WORD_W-1:0] read_data;
    logic                        read_last;
    logic                        word_dropped;
  } reasm_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        cfg_wr_en = 1'b0;
  logic [psmr_pkg::NODE_W-1:0] cfg_wr_data = '0;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_action = psmr_pkg::ACT_STORE;
  logic [psmr_pkg::NODE_W-1:0] in_source_node = '0;
  logic [psmr_pkg::WORD_W-1:0] in_word_data = '0;
  logic                        in_packet_last = 1'b0;

  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [psmr_pkg::WORD_W-1:0] out_read_data;
  logic                        out_read_last;
  logic                        out_word_dropped;

  // items waiting to be offered and results waiting to come back
  reasm_item_t   pending_items[$];
  reasm_result_t expected_results[$];

  // private copy of the block state used for prediction
  logic [psmr_pkg::WORD_W-1:0] model_store [STORE_WORDS];
  logic [6:0]                  model_fill [REGIONS];
  logic [7:0]                  model_rd_ptr;
  logic [psmr_pkg::NODE_W-1:0] model_own_node;

  // read position as seen by the stimulus generator, used to size a full read-out
  int gen_rd_ptr = 0;

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // handshake bookkeeping between the driver and the monitor
  bit offer_open = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  int error_count = 0;
  int cycle_count = 0;

  per_source_message_reassembly #(
    .NODES        (NODES),
    .MESSAGE_WORDS(MESSAGE_WORDS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_source_node  (in_source_node),
    .in_word_data    (in_word_data),
    .in_packet_last  (in_packet_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_read_last   (out_read_last),
    .out_word_dropped(out_word_dropped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one accepted item to the private state and return what the block must answer
  function automatic reasm_result_t reassemble_and_predict(input reasm_item_t it);
    reasm_result_t r;
    int region;
    r = '0;
    if (it.action == psmr_pkg::ACT_STORE) begin
      // own id takes no region, ids above it shift down by one
      if (it.source_node == model_own_node) begin
        r.word_dropped = 1'b1;
      end else begin
        region = (it.source_node > model_own_node) ? int'(it.source_node) - 1
                                                   : int'(it.source_node);
        if (region >= REGIONS) begin
          r.word_dropped = 1'b1;
        end else if (model_fill[region] >= MESSAGE_WORDS) begin
          // region full: the word never spills into the next region
          r.word_dropped = 1'b1;
        end else begin
          model_store[region * MESSAGE_WORDS + int'(model_fill[region])] = it.word_data;
          model_fill[region] = model_fill[region] + 7'd1;
        end
      end
    end else begin
      if (model_rd_ptr >= STORE_WORDS) begin
        model_rd_ptr = '0;
      end
      r.read_data = model_store[model_rd_ptr];
      if (model_rd_ptr == STORE_WORDS - 1) begin
        // final word of the store: read pointer and all fills start over
        r.read_last = 1'b1;
        model_rd_ptr = '0;
        for (int i = 0; i < REGIONS; i++) begin
          model_fill[i] = '0;
        end
      end else begin
        model_rd_ptr = model_rd_ptr + 8'd1;
      end
    end
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // monitor: check the returned item first, then record the accepted input item
  always @(posedge clk) begin
    reasm_result_t got;
    reasm_result_t want;
    cycle_count++;
    if (rst_n && out_valid && !out_stall) begin
      got = '{read_data: out_read_data, read_last: out_read_last,
              word_dropped: out_word_dropped};
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result item: expected none actual %h", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("read_last", want.read_last, got.read_last);
        compare_field("word_dropped", want.word_dropped, got.word_dropped);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(reassemble_and_predict(pending_items.pop_front()));
      offer_open = 1'b0;
    end
  end

  // driver: an offered item stays on the port until it is taken
  always @(negedge clk) begin
    if (!offer_open) begin
      if (rst_n && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid       <= 1'b1;
        in_action      <= pending_items[0].action;
        in_source_node <= pending_items[0].source_node;
        in_word_data   <= pending_items[0].word_data;
        in_packet_last <= pending_items[0].packet_last;
        offer_open = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, or a long hold-off counted here when requested
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t timeout after %0d cycles", $time, cycle_count);
    $display("Verification failed");
    $finish;
  end

  task automatic queue_item(input logic action, input logic [1:0] src,
                            input logic [31:0] data, input logic last);
    pending_items.push_back('{action: action, source_node: src, word_data: data,
                              packet_last: last});
    if (action == psmr_pkg::ACT_READ) begin
      gen_rd_ptr = (gen_rd_ptr == STORE_WORDS - 1) ? 0 : gen_rd_ptr + 1;
    end
  endtask

  // one packet of random words from one source, last word marked
  task automatic queue_packet(input logic [1:0] src, input int len);
    for (int i = 0; i < len; i++) begin
      queue_item(psmr_pkg::ACT_STORE, src, $urandom, (i == len - 1));
    end
  endtask

  task automatic queue_reads(input int count);
    for (int i = 0; i < count; i++) begin
      queue_item(psmr_pkg::ACT_READ, 2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
    end
  endtask

  // read out the rest of the store so that the final word comes back
  task automatic queue_full_readout(output int count);
    count = STORE_WORDS - gen_rd_ptr;
    queue_reads(count);
  endtask

  // mostly well-formed traffic: packets, read bursts, full read-outs, floods and noise
  task automatic queue_random_traffic(input int budget);
    int made;
    int kind;
    int len;
    made = 0;
    while (made < budget) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        len = $urandom_range(12, 1);
        queue_packet(2'($urandom_range(3)), len);
      end else if (kind < 75) begin
        len = $urandom_range(6, 1);
        queue_reads(len);
      end else if (kind < 83) begin
        queue_full_readout(len);
      end else if (kind < 93) begin
        // up to 72 words from one source, which can run past its 64-word region
        len = $urandom_range(72, 60);
        queue_packet(2'($urandom_range(3)), len);
      end else begin
        len = 1;
        queue_item(1'($urandom_range(1)), 2'($urandom_range(3)), $urandom,
                   1'($urandom_range(1)));
      end
      made += len;
    end
  endtask

  // hold until nothing is waiting on either side
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0 || offer_open) begin
      @(posedge clk);
    end
  endtask

  // register write while the block is idle, mirrored into the private state
  task automatic write_own_node(input logic [1:0] id);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= id;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_own_node = id;
  endtask

  initial begin
    int dummy;
    // reset state of the private copy
    for (int i = 0; i < STORE_WORDS; i++) begin
      model_store[i] = '0;
    end
    for (int i = 0; i < REGIONS; i++) begin
      model_fill[i] = '0;
    end
    model_rd_ptr   = '0;
    model_own_node = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the clearing pass after reset keeps the input stalled
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end

    // directed: own id zero
    write_own_node(2'd0);
    queue_item(psmr_pkg::ACT_READ, 2'd0, 32'h0, 1'b0);            // read while filling
    queue_item(psmr_pkg::ACT_STORE, 2'd0, 32'hffff_ffff, 1'b1);   // own source
    queue_item(psmr_pkg::ACT_STORE, 2'd1, 32'h0000_0000, 1'b0);
    queue_item(psmr_pkg::ACT_STORE, 2'd1, 32'hffff_ffff, 1'b1);
    queue_item(psmr_pkg::ACT_STORE, 2'd2, 32'ha5a5_a5a5, 1'b1);
    queue_item(psmr_pkg::ACT_STORE, 2'd3, 32'h5a5a_5a5a, 1'b1);
    queue_item(psmr_pkg::ACT_READ, 2'd3, 32'hffff_ffff, 1'b1);
    queue_item(psmr_pkg::ACT_READ, 2'd2, 32'h0, 1'b0);
    wait_drained();

    // directed: own id at the top, low ids keep their regions
    write_own_node(2'd3);
    queue_item(psmr_pkg::ACT_STORE, 2'd3, 32'h1234_5678, 1'b0);   // own source
    queue_item(psmr_pkg::ACT_STORE, 2'd0, 32'h8765_4321, 1'b0);
    queue_item(psmr_pkg::ACT_STORE, 2'd2, 32'hdead_beef, 1'b1);
    queue_item(psmr_pkg::ACT_STORE, 2'd1, 32'h0f0f_0f0f, 1'b1);
    queue_item(psmr_pkg::ACT_READ, 2'd0, 32'h0, 1'b0);
    queue_item(psmr_pkg::ACT_READ, 2'd1, 32'h0, 1'b1);
    queue_item(psmr_pkg::ACT_READ, 2'd2, 32'h0, 1'b0);
    wait_drained();

    // no idling, with one long receiver hold-off that backs up the input
    write_own_node(2'd3);
    queue_random_traffic(150);
    hold_request = 1'b1;
    wait_drained();

    // sender idle most cycles, ends with a full read-out
    write_own_node(2'd1);
    send_idle_pct = 78;
    queue_random_traffic(150);
    queue_full_readout(dummy);
    wait_drained();

    // receiver stalls most cycles, sender pauses midway until all results are back
    write_own_node(2'd2);
    send_idle_pct  = 0;
    recv_stall_pct = 78;
    queue_random_traffic(75);
    wait_drained();
    queue_random_traffic(75);
    wait_drained();

    // both sides idle now and then
    write_own_node(2'd0);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    queue_random_traffic(150);
    wait_drained();

    // let a stray extra result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
